// ===== src/hrtp_pkg.sv =====
// Shared types and constants for the HEVC RTP depacketizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hrtp_pkg;

  // One payload beat as it enters the block.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        pkt_first;
    logic        last_byte;
    logic [15:0] seq_num;
  } hrtp_in_t;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       nal_start;
    logic [5:0] unit_type;
    logic       packet_end;
    logic [2:0] status;
    logic       fu_open;
    logic       last_of_item;
  } hrtp_out_t;

  // Closing status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_TRUNC_PAYLOAD = 3'd1;
  localparam logic [2:0] ST_BAD_AGG_LEN   = 3'd2;
  localparam logic [2:0] ST_TRUNC_AGG     = 3'd3;
  localparam logic [2:0] ST_TRUNC_FRAG    = 3'd4;
  localparam logic [2:0] ST_FRAG_DISCONT  = 3'd5;

  // Payload header types handled specially.
  localparam logic [5:0] NAL_TYPE_AP = 6'd48;
  localparam logic [5:0] NAL_TYPE_FU = 6'd49;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR2,
    PH_SINGLE,
    PH_AGG_HI,
    PH_AGG_LO,
    PH_AGG_FIRST,
    PH_AGG_BODY,
    PH_FU_HDR,
    PH_FU_BODY,
    PH_DISCARD
  } hrtp_phase_t;

  // Compact description of all results one input beat causes, in output order:
  // an early truncation close, a start code, up to two stream bytes, a close.
  typedef struct packed {
    logic       pre_fail;
    logic       start;
    logic [5:0] start_type;
    logic       b0_en;
    logic [7:0] b0;
    logic       b1_en;
    logic [7:0] b1;
    logic       close;
    logic [2:0] close_status;
    logic       close_fu;
  } hrtp_cmd_t;

  // Result slots of a command: bit 0 early close, bits 1..4 start code,
  // bits 5 and 6 the stream bytes, bit 7 the closing status.
  function automatic logic [7:0] cmd_slots(hrtp_cmd_t c);
    cmd_slots = {c.close, c.b1_en, c.b0_en, c.start, c.start, c.start, c.start,
                 c.pre_fail};
  endfunction

endpackage

// ===== src/hrtp_front.sv =====
// Front end of the depacketizer: parses payload beats and builds commands.
// Depends on hrtp_pkg.
`timescale 1ns / 1ps

module hrtp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  hrtp_pkg::hrtp_in_t payload,
  output hrtp_pkg::hrtp_cmd_t cmd,
  output logic              cmd_valid
);
  import hrtp_pkg::*;

  hrtp_phase_t phase, phase_next;
  logic [7:0]  hdr_first, hdr_first_next;
  logic [7:0]  hdr_second, hdr_second_next;
  logic [7:0]  len_high, len_high_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] pkt_seq, pkt_seq_next;
  logic        frag_active, frag_active_next;
  logic [15:0] frag_seq, frag_seq_next;
  logic [5:0]  frag_kind, frag_kind_next;

  logic        fail_now;
  logic [2:0]  fail_code;
  logic        fail_discard;
  logic        close_ok;
  logic [5:0]  hdr_type;
  logic [5:0]  orig;
  logic [15:0] len_word;
  hrtp_cmd_t   c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hdr_first   <= '0;
      hdr_second  <= '0;
      len_high    <= '0;
      remaining   <= '0;
      pkt_seq     <= '0;
      frag_active <= 1'b0;
      frag_seq    <= '0;
      frag_kind   <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_first   <= hdr_first_next;
      hdr_second  <= hdr_second_next;
      len_high    <= len_high_next;
      remaining   <= remaining_next;
      pkt_seq     <= pkt_seq_next;
      frag_active <= frag_active_next;
      frag_seq    <= frag_seq_next;
      frag_kind   <= frag_kind_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    hdr_first_next   = hdr_first;
    hdr_second_next  = hdr_second;
    len_high_next    = len_high;
    remaining_next   = remaining;
    pkt_seq_next     = pkt_seq;
    frag_active_next = frag_active;
    frag_seq_next    = frag_seq;
    frag_kind_next   = frag_kind;
    fail_now         = 1'b0;
    fail_code        = ST_OK;
    fail_discard     = 1'b0;
    close_ok         = 1'b0;
    hdr_type         = hdr_first[6:1];
    orig             = payload.data_byte[5:0];
    len_word         = {len_high, payload.data_byte};
    c                = '0;

    if (payload.pkt_first) begin
      if (phase != PH_IDLE && phase != PH_DISCARD) begin
        // A new packet cuts the previous one short.
        c.pre_fail       = 1'b1;
        frag_active_next = 1'b0;
        frag_seq_next    = '0;
        frag_kind_next   = '0;
      end
      pkt_seq_next   = payload.seq_num;
      hdr_first_next = payload.data_byte;
      if (payload.last_byte) begin
        fail_now  = 1'b1;
        fail_code = ST_TRUNC_PAYLOAD;
      end else begin
        phase_next = PH_HDR2;
      end
    end else begin
      case (phase)
        PH_HDR2: begin
          hdr_second_next = payload.data_byte;
          if (hdr_type == NAL_TYPE_AP) begin
            frag_active_next = 1'b0;
            frag_seq_next    = '0;
            frag_kind_next   = '0;
            if (payload.last_byte) begin
              fail_now  = 1'b1;
              fail_code = ST_TRUNC_AGG;
            end else begin
              phase_next = PH_AGG_HI;
            end
          end else if (hdr_type == NAL_TYPE_FU) begin
            if (payload.last_byte) begin
              fail_now  = 1'b1;
              fail_code = ST_TRUNC_FRAG;
            end else begin
              phase_next = PH_FU_HDR;
            end
          end else begin
            frag_active_next = 1'b0;
            frag_seq_next    = '0;
            frag_kind_next   = '0;
            c.start      = 1'b1;
            c.start_type = hdr_type;
            c.b0_en      = 1'b1;
            c.b0         = hdr_first;
            c.b1_en      = 1'b1;
            c.b1         = payload.data_byte;
            if (payload.last_byte) begin
              close_ok = 1'b1;
            end else begin
              phase_next = PH_SINGLE;
            end
          end
        end
        PH_SINGLE, PH_FU_BODY: begin
          c.b0_en = 1'b1;
          c.b0    = payload.data_byte;
          if (payload.last_byte) begin
            close_ok = 1'b1;
          end
        end
        PH_AGG_HI: begin
          len_high_next = payload.data_byte;
          if (payload.last_byte) begin
            fail_now  = 1'b1;
            fail_code = ST_TRUNC_AGG;
          end else begin
            phase_next = PH_AGG_LO;
          end
        end
        PH_AGG_LO: begin
          remaining_next = len_word;
          if (len_word < 16'd2 || payload.last_byte) begin
            fail_now     = 1'b1;
            fail_code    = ST_BAD_AGG_LEN;
            fail_discard = !payload.last_byte;
          end else begin
            phase_next = PH_AGG_FIRST;
          end
        end
        PH_AGG_FIRST: begin
          if (payload.last_byte) begin
            fail_now  = 1'b1;
            fail_code = ST_BAD_AGG_LEN;
          end else begin
            c.start        = 1'b1;
            c.start_type   = payload.data_byte[6:1];
            c.b0_en        = 1'b1;
            c.b0           = payload.data_byte;
            remaining_next = remaining - 16'd1;
            phase_next     = PH_AGG_BODY;
          end
        end
        PH_AGG_BODY: begin
          if (payload.last_byte && remaining != 16'd1) begin
            fail_now  = 1'b1;
            fail_code = ST_BAD_AGG_LEN;
          end else begin
            c.b0_en        = 1'b1;
            c.b0           = payload.data_byte;
            remaining_next = remaining - 16'd1;
            if (payload.last_byte) begin
              close_ok = 1'b1;
            end else if (remaining == 16'd1) begin
              phase_next = PH_AGG_HI;
            end
          end
        end
        PH_FU_HDR: begin
          if (payload.last_byte) begin
            fail_now  = 1'b1;
            fail_code = ST_TRUNC_FRAG;
          end else if (payload.data_byte[7]) begin
            // Start fragment: rebuild the original NAL header.
            frag_active_next = 1'b0;
            frag_seq_next    = '0;
            frag_kind_next   = '0;
            c.start      = 1'b1;
            c.start_type = orig;
            c.b0_en      = 1'b1;
            c.b0         = {hdr_first[7], orig, hdr_first[0]};
            c.b1_en      = 1'b1;
            c.b1         = hdr_second;
            if (!payload.data_byte[6]) begin
              frag_active_next = 1'b1;
              frag_seq_next    = pkt_seq + 16'd1;
              frag_kind_next   = orig;
            end
            phase_next = PH_FU_BODY;
          end else if (!frag_active || pkt_seq != frag_seq || orig != frag_kind) begin
            fail_now     = 1'b1;
            fail_code    = ST_FRAG_DISCONT;
            fail_discard = 1'b1;
          end else begin
            if (payload.data_byte[6]) begin
              frag_active_next = 1'b0;
              frag_seq_next    = '0;
              frag_kind_next   = '0;
            end else begin
              frag_seq_next = pkt_seq + 16'd1;
            end
            phase_next = PH_FU_BODY;
          end
        end
        PH_DISCARD: begin
          if (payload.last_byte) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    if (fail_now) begin
      frag_active_next = 1'b0;
      frag_seq_next    = '0;
      frag_kind_next   = '0;
      remaining_next   = '0;
      c.close          = 1'b1;
      c.close_status   = fail_code;
      c.close_fu       = 1'b0;
      phase_next       = fail_discard ? PH_DISCARD : PH_IDLE;
    end else if (close_ok) begin
      c.close        = 1'b1;
      c.close_status = ST_OK;
      c.close_fu     = frag_active_next;
      phase_next     = PH_IDLE;
    end

    cmd       = c;
    cmd_valid = accept && (|cmd_slots(c));
  end

endmodule

// ===== src/hrtp_cmd_fifo.sv =====
// Short command queue between the parser and the result expander.
// Depends on hrtp_pkg for the command type.
`timescale 1ns / 1ps

module hrtp_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  hrtp_pkg::hrtp_cmd_t wr_data,
  input  logic                rd_en,
  output hrtp_pkg::hrtp_cmd_t rd_data,
  output logic                fifo_full,
  output logic                fifo_empty
);
  import hrtp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hrtp_cmd_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign fifo_full  = (count == FULL_CNT);
  assign fifo_empty = (count == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/hrtp_back.sv =====
// Back end of the depacketizer: expands each command into result beats in
// the output register, one per cycle unless stalled. Depends on hrtp_pkg.
`timescale 1ns / 1ps

module hrtp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  hrtp_pkg::hrtp_cmd_t  fifo_cmd,
  input  logic                 fifo_empty,
  output logic                 fifo_pop,
  input  logic                 pop,
  output logic                 empty,
  output hrtp_pkg::hrtp_out_t  result
);
  import hrtp_pkg::*;

  hrtp_cmd_t  cur;
  logic [7:0] slots, slots_next;
  logic [7:0] slot_low;
  logic [7:0] slot_rest;
  logic       out_valid;
  logic       adv;
  logic       emit;
  hrtp_out_t  beat;

  assign slot_low  = slots & (~slots + 8'd1);
  assign slot_rest = slots & ~slot_low;
  assign adv       = !out_valid || pop;
  assign emit      = (slots != '0) && adv;
  assign fifo_pop  = !fifo_empty && ((slots == '0) || (emit && slot_rest == '0));
  assign empty     = !out_valid;

  always_comb begin
    if (fifo_pop) begin
      slots_next = cmd_slots(fifo_cmd);
    end else if (emit) begin
      slots_next = slot_rest;
    end else begin
      slots_next = slots;
    end
  end

  always_comb begin
    beat = '0;
    case (slot_low)
      8'b0000_0001: begin
        beat.packet_end = 1'b1;
        beat.status     = ST_TRUNC_PAYLOAD;
      end
      8'b0000_0010: begin
        beat.byte_valid = 1'b1;
        beat.nal_start  = 1'b1;
        beat.unit_type  = cur.start_type;
      end
      8'b0000_0100, 8'b0000_1000: begin
        beat.byte_valid = 1'b1;
      end
      8'b0001_0000: begin
        beat.byte_valid = 1'b1;
        beat.out_byte   = 8'h01;
      end
      8'b0010_0000: begin
        beat.byte_valid = 1'b1;
        beat.out_byte   = cur.b0;
      end
      8'b0100_0000: begin
        beat.byte_valid = 1'b1;
        beat.out_byte   = cur.b1;
      end
      8'b1000_0000: begin
        beat.packet_end = 1'b1;
        beat.status     = cur.close_status;
        beat.fu_open    = cur.close_fu;
      end
      default: begin
      end
    endcase
    beat.last_of_item = (slot_rest == '0);
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cur <= fifo_cmd;
    end
    if (emit) begin
      result <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots     <= '0;
      out_valid <= 1'b0;
    end else begin
      slots <= slots_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/hevc_rtp_depacketizer.sv =====
// Top level of the HEVC RTP depacketizer: parser, command queue, expander.
// Depends on hrtp_pkg, hrtp_front, hrtp_cmd_fifo and hrtp_back.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one RTP payload byte per beat, marked with
// pkt_first and last_byte and carrying the packet's sequence number. A beat
// is taken when push is high and full is low. The result channel presents
// the oldest result beat while empty is low; pop takes it. Results form an
// Annex-B stream: each NAL unit opens with 00 00 00 01 (nal_start and
// unit_type mark its first byte), and each packet closes with one status beat
// (packet_end, status, fu_open). On a non-zero status the receiver
// must drop the bytes of that packet that were already delivered.
// Throughput: the parser takes one byte per cycle while full is low; the
// expander delivers one result beat per cycle unless the receiver stalls,
// and a byte can cause up to seven results (a start code, two header bytes
// and a closing status beat). The command queue of QUEUE_DEPTH entries
// absorbs those bursts. Reset clears the parser, the queue and the output
// register. When the receiver stalls, the output register holds, the queue
// fills and full rises; nothing is lost.
module hevc_rtp_depacketizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hrtp_pkg::hrtp_in_t  payload,
  input  logic                pop,
  output logic                empty,
  output hrtp_pkg::hrtp_out_t result
);
  import hrtp_pkg::*;

  logic      accept;
  hrtp_cmd_t front_cmd;
  logic      front_cmd_valid;
  hrtp_cmd_t queue_cmd;
  logic      queue_full;
  logic      queue_empty;
  logic      queue_pop;

  // A byte is taken only while the queue can hold whatever it causes.
  assign full   = queue_full;
  assign accept = push && !queue_full;

  hrtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .payload   (payload),
    .cmd       (front_cmd),
    .cmd_valid (front_cmd_valid)
  );

  hrtp_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (front_cmd_valid),
    .wr_data    (front_cmd),
    .rd_en      (queue_pop),
    .rd_data    (queue_cmd),
    .fifo_full  (queue_full),
    .fifo_empty (queue_empty)
  );

  hrtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_cmd   (queue_cmd),
    .fifo_empty (queue_empty),
    .fifo_pop   (queue_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
